### src/hmtp_pkg.sv
// shared types, codes and helpers for the height map token parser
package hmtp_pkg;

	localparam int unsigned ROWS_MAX_DEF = 1024;
	localparam int unsigned COLS_MAX_DEF = 1024;

	localparam int unsigned CNT_W  = 11;
	localparam int unsigned IDX_W  = 10;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_X_LO    = 8'h78;
	localparam logic [7:0] CH_X_UP    = 8'h58;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;

	typedef enum logic [8:0] {
		PH_LINE_START = 9'b000000001,
		PH_GAP        = 9'b000000010,
		PH_Z_SPACE    = 9'b000000100,
		PH_Z_DIGITS   = 9'b000001000,
		PH_Z_DONE     = 9'b000010000,
		PH_C_START    = 9'b000100000,
		PH_C_ZERO     = 9'b001000000,
		PH_C_DIGITS   = 9'b010000000,
		PH_C_DONE     = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] row_lim;
		logic [CNT_W-1:0] col_lim;
	} limits_t;

	typedef struct packed {
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [WORD_W-1:0] z_value;
		logic [WORD_W-1:0]        color_value;
		logic                     color_present;
		logic signed [WORD_W-1:0] low_mark;
		logic signed [WORD_W-1:0] high_mark;
		logic                     row_end;
	} result_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// bit 4 set when c is a hex digit, low bits give its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

### src/hmtp_parser.sv
// byte parse state, token close and running height bounds
module hmtp_parser
	import hmtp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          ch,
	input  logic                end_of_input,
	input  limits_t             lim,
	output logic                res_valid,
	output result_t             res
);

	phase_t                   phase_q, ph_n;
	logic                     skip_q, skip_n;
	logic [WORD_W-1:0]        zacc_q, zacc_n;
	logic                     neg_q, neg_n;
	logic [WORD_W-1:0]        cacc_q, cacc_n;
	logic                     comma_q, comma_n;
	logic [CNT_W-1:0]         row_q, row_n;
	logic [CNT_W-1:0]         col_q, col_n;
	logic signed [WORD_W-1:0] min_q, min_n;
	logic signed [WORD_W-1:0] max_q, max_n;

	logic                     do_close, do_end, close_end, kept;
	logic [4:0]               hd;
	logic signed [WORD_W-1:0] zs;
	logic                     tok_open;

	assign tok_open = (phase_q != PH_LINE_START) && (phase_q != PH_GAP);

	always_comb begin
		ph_n      = phase_q;
		skip_n    = skip_q;
		zacc_n    = zacc_q;
		neg_n     = neg_q;
		cacc_n    = cacc_q;
		comma_n   = comma_q;
		row_n     = row_q;
		col_n     = col_q;
		min_n     = min_q;
		max_n     = max_q;
		do_close  = 1'b0;
		do_end    = 1'b0;
		close_end = 1'b0;
		kept      = 1'b0;
		zs        = '0;
		res_valid = 1'b0;
		res       = '0;
		hd        = hex_digit(ch);

		if (end_of_input) begin
			do_close  = tok_open;
			close_end = 1'b1;
			do_end    = (phase_q != PH_LINE_START);
		end else if (!(phase_q == PH_LINE_START && ch == CH_NEWLINE)) begin
			if (phase_q == PH_LINE_START) begin
				skip_n = (row_q >= lim.row_lim);
				col_n  = '0;
				ph_n   = PH_GAP;
			end
			if (ch == CH_SPACE) begin
				do_close = (ph_n != PH_GAP);
			end else begin
				if (ph_n == PH_GAP) begin
					ph_n    = PH_Z_SPACE;
					zacc_n  = '0;
					neg_n   = 1'b0;
					cacc_n  = '0;
					comma_n = 1'b0;
				end
				if (ch == CH_NEWLINE) begin
					do_close  = 1'b1;
					close_end = 1'b1;
					do_end    = 1'b1;
				end else begin
					case (ph_n)
						PH_Z_SPACE: begin
							if (ch >= CH_TAB && ch <= CH_CR) begin
								ph_n = PH_Z_SPACE;
							end else if (ch == CH_PLUS || ch == CH_MINUS) begin
								neg_n = (ch == CH_MINUS);
								ph_n  = PH_Z_DIGITS;
							end else if (is_dec(ch)) begin
								zacc_n = {24'd0, ch - CH_ZERO};
								ph_n   = PH_Z_DIGITS;
							end else if (ch == CH_COMMA) begin
								comma_n = 1'b1;
								ph_n    = PH_C_START;
							end else begin
								ph_n = PH_Z_DONE;
							end
						end
						PH_Z_DIGITS: begin
							if (is_dec(ch)) begin
								zacc_n = (zacc_n << 3) + (zacc_n << 1) + {24'd0, ch - CH_ZERO};
							end else if (ch == CH_COMMA) begin
								comma_n = 1'b1;
								ph_n    = PH_C_START;
							end else begin
								ph_n = PH_Z_DONE;
							end
						end
						PH_Z_DONE: begin
							if (ch == CH_COMMA) begin
								comma_n = 1'b1;
								ph_n    = PH_C_START;
							end
						end
						PH_C_START: begin
							if (ch == CH_ZERO) begin
								cacc_n = '0;
								ph_n   = PH_C_ZERO;
							end else if (hd[4]) begin
								cacc_n = {28'd0, hd[3:0]};
								ph_n   = PH_C_DIGITS;
							end else begin
								ph_n = PH_C_DONE;
							end
						end
						PH_C_ZERO: begin
							if (ch == CH_X_LO || ch == CH_X_UP) begin
								ph_n = PH_C_DIGITS;
							end else if (hd[4]) begin
								cacc_n = {cacc_n[WORD_W-5:0], hd[3:0]};
								ph_n   = PH_C_DIGITS;
							end else begin
								ph_n = PH_C_DONE;
							end
						end
						PH_C_DIGITS: begin
							if (hd[4]) begin
								cacc_n = {cacc_n[WORD_W-5:0], hd[3:0]};
							end else begin
								ph_n = PH_C_DONE;
							end
						end
						default: begin
							ph_n = ph_n;
						end
					endcase
				end
			end
		end

		if (do_close) begin
			kept = !skip_n && (col_n < lim.col_lim);
			ph_n = PH_GAP;
			zs   = neg_n ? $signed(WORD_W'(0) - zacc_n) : $signed(zacc_n);
			if (kept) begin
				if (zs < min_n) begin
					min_n = zs;
				end
				if (zs > max_n) begin
					max_n = zs;
				end
				res_valid         = 1'b1;
				res.row_index     = row_n[IDX_W-1:0];
				res.col_index     = col_n[IDX_W-1:0];
				res.z_value       = zs;
				res.color_value   = comma_n ? cacc_n : '0;
				res.color_present = comma_n;
				res.low_mark      = min_n;
				res.high_mark     = max_n;
				res.row_end       = close_end;
			end
			if (col_n < lim.col_lim) begin
				col_n = col_n + 1'b1;
			end
		end
		if (do_end) begin
			if (!skip_n) begin
				row_n = row_n + 1'b1;
			end
			ph_n = PH_LINE_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_START;
			skip_q  <= 1'b0;
			zacc_q  <= '0;
			neg_q   <= 1'b0;
			cacc_q  <= '0;
			comma_q <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end else if (fire) begin
			phase_q <= ph_n;
			skip_q  <= skip_n;
			zacc_q  <= zacc_n;
			neg_q   <= neg_n;
			cacc_q  <= cacc_n;
			comma_q <= comma_n;
			row_q   <= row_n;
			col_q   <= col_n;
			min_q   <= min_n;
			max_q   <= max_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_bounds_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(min_q <= 0) && (max_q >= 0))
		else $error("height bounds no longer include zero");

	a_result_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.low_mark <= res.z_value) && (res.z_value <= res.high_mark))
		else $error("result height outside its bounds");

	a_kept_column: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid) |=> (col_q != '0) && (col_q <= $past(lim.col_lim)))
		else $error("kept token past column limit");
`endif

endmodule

### src/hmtp_out_buf.sv
// two-entry result buffer between parser and output channel
module hmtp_out_buf
	import hmtp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t     buf0_q, buf1_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf0_q;
	assign space     = (cnt_q != 2'd2);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				buf0_q <= push_data;
			end else begin
				buf0_q <= buf1_q;
			end
			if (push && cnt_q == 2'd2) begin
				buf1_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				buf0_q <= push_data;
			end else begin
				buf1_q <= push_data;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3) && !(push && !pop && cnt_q == 2'd2))
		else $error("result buffer overflow");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_data == $past(out_data)))
		else $error("waiting result changed");
`endif

endmodule

### src/heightmap_token_parser_top.sv
// height map text tokeniser: takes one byte per transfer, gives one point per kept token
//
// input channel: in_valid/in_ready carry ch and end_of_input; one byte per transfer,
// end_of_input flushes the open token and closes the line
// output channel: out_valid/out_ready carry one point per kept token with row,
// column, height, colour and the running minimum and maximum height
// config channel: cfg_valid/cfg_ready with cfg_index (0 row_count, 1 col_count)
// and cfg_data; always ready, write only while the block is idle
// throughput: one byte per cycle while in_ready is high; the parse state updates in the cycle of the transfer
// a result is registered in the result buffer at the transfer of the byte that closes its token
// a two-entry result buffer decouples the sides; in_ready drops only when both
// entries hold results the receiver has not taken, so a stall backs up after two
// reset: parse at line start, counters and height bounds zero, both limits 1024,
// result buffer empty
module heightmap_token_parser_top
	import hmtp_pkg::*;
#(
	parameter int unsigned ROWS_MAX = ROWS_MAX_DEF,
	parameter int unsigned COLS_MAX = COLS_MAX_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               ch,
	input  logic                     end_of_input,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         row_index,
	output logic [IDX_W-1:0]         col_index,
	output logic signed [WORD_W-1:0] z_value,
	output logic [WORD_W-1:0]        color_value,
	output logic                     color_present,
	output logic signed [WORD_W-1:0] low_mark,
	output logic signed [WORD_W-1:0] high_mark,
	output logic                     row_end,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CNT_W-1:0]         cfg_data
);

	localparam logic [16:0] ROWS_LIM = 17'(ROWS_MAX);
	localparam logic [16:0] COLS_LIM = 17'(COLS_MAX);

	logic [CNT_W-1:0] row_count_q, col_count_q;
	limits_t          lim;
	logic             fire, space, res_valid;
	result_t          res, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= COUNT_RESET;
			col_count_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
				default: row_count_q <= row_count_q;
			endcase
		end
	end

	assign lim.row_lim = ({6'd0, row_count_q} < ROWS_LIM) ? row_count_q : ROWS_LIM[CNT_W-1:0];
	assign lim.col_lim = ({6'd0, col_count_q} < COLS_LIM) ? col_count_q : COLS_LIM[CNT_W-1:0];

	assign in_ready = space;
	assign fire     = in_valid && space;

	hmtp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.ch           (ch),
		.end_of_input (end_of_input),
		.lim          (lim),
		.res_valid    (res_valid),
		.res          (res)
	);

	hmtp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (head)
	);

	assign row_index     = head.row_index;
	assign col_index     = head.col_index;
	assign z_value       = head.z_value;
	assign color_value   = head.color_value;
	assign color_present = head.color_present;
	assign low_mark      = head.low_mark;
	assign high_mark     = head.high_mark;
	assign row_end       = head.row_end;

endmodule
